>>> hdl/gn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn_pkg
// Shared constants and types for the gradient noise block.
// ----------------------------------------------------------------------------
package gn_pkg;

  localparam int TABLE_SIZE_DEF    = 256;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH       = 4;
  localparam int HASH_N            = 8;

  localparam int COORD_W = 32;
  localparam int ENTRY_W = 8;
  localparam int MODE_W  = 2;
  localparam int OUT_W   = 18;
  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  localparam logic REQ_EVAL = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  localparam logic [MODE_W-1:0] MODE_2D    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd3;

  // Queue occupancy flags seen by both sides of the queue.
  typedef struct packed {
    logic empty;
    logic full;
  } gn_q_status_t;

  // Hand-off from the table sequencer to the arithmetic pipeline.
  typedef struct packed {
    logic vld;
    logic two_d;
  } gn_launch_t;

endpackage

>>> hdl/gradient_noise_2d_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_2d_3d
// Improved gradient noise in two or three dimensions over a loadable table.
// ----------------------------------------------------------------------------
// Usage: raise start with an item on the input ports; the item is taken at
// any rising edge where start is high and busy is low. An evaluate item
// (req_type 0) carries Q16.16 coordinates and yields one result; a load item
// (req_type 1) writes entry_value into table slot entry_index and yields none.
// Each result appears on noise_value for exactly one cycle with noise_valid
// high, in item order. The receiver cannot stall, so the output never waits.
// Items enter a four-deep queue; busy rises when that queue is full and
// during the reset sweep.
// The table lives in a memory with two read ports, which sets the rate: the
// hash chain takes two reads per step, a 3D item walks more steps than a 2D
// one, and a load only writes its slot. The sequencer takes the next item
// once it is back in idle; the arithmetic behind it is fully pipelined.
// After reset the table is swept to the identity, one entry per cycle, which
// holds busy high until the sweep ends. dimension_mode resets to 3 and is
// written over the cfg channel, which is always ready; 2 selects 2D noise and
// any other value 3D. Write it only while no item is in flight.
// ----------------------------------------------------------------------------
module gradient_noise_2d_3d #(
  parameter int TABLE_SIZE    = gn_pkg::TABLE_SIZE_DEF,
  parameter int FRACTION_BITS = gn_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              req_type,
  input  logic signed [gn_pkg::COORD_W-1:0] coord_x,
  input  logic signed [gn_pkg::COORD_W-1:0] coord_y,
  input  logic signed [gn_pkg::COORD_W-1:0] coord_z,
  input  logic        [gn_pkg::ENTRY_W-1:0] entry_index,
  input  logic        [gn_pkg::ENTRY_W-1:0] entry_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic        [gn_pkg::MODE_W-1:0]  cfg_data,
  output logic                              noise_valid,
  output logic signed [gn_pkg::OUT_W-1:0]   noise_value
);
  import gn_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int QW = 1 + 4 * IW + 3 * FRACTION_BITS + ENTRY_W;

  logic [MODE_W-1:0]                dimension_mode;
  logic [QW-1:0]                    front_item, head_item;
  logic                             push, pop, clearing;
  gn_q_status_t                     q_status;
  gn_launch_t                       launch;
  logic [HASH_N-1:0][ENTRY_W-1:0]   hash;
  logic [FRACTION_BITS-1:0]         frac_x, frac_y, frac_z;

  // The mode register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension_mode <= MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dimension_mode <= cfg_data;
    end
  end

  // Intake stalls only for the reset sweep or a full queue.
  assign busy = clearing || q_status.full;
  assign push = start && !busy;

  gn_front #(
    .TABLE_SIZE    (TABLE_SIZE),
    .FRACTION_BITS (FRACTION_BITS),
    .IW            (IW),
    .QW            (QW)
  ) u_front (
    .req_type    (req_type),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .item        (front_item)
  );

  gn_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_item),
    .pop       (pop),
    .pop_data  (head_item),
    .status    (q_status)
  );

  gn_seq #(
    .TABLE_SIZE    (TABLE_SIZE),
    .FRACTION_BITS (FRACTION_BITS),
    .IW            (IW),
    .QW            (QW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .mode     (dimension_mode),
    .q_status (q_status),
    .q_item   (head_item),
    .q_pop    (pop),
    .clearing (clearing),
    .launch   (launch),
    .hash     (hash),
    .frac_x   (frac_x),
    .frac_y   (frac_y),
    .frac_z   (frac_z)
  );

  gn_lerp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_lerp (
    .clk         (clk),
    .rst         (rst),
    .launch      (launch),
    .hash        (hash),
    .frac_x      (frac_x),
    .frac_y      (frac_y),
    .frac_z      (frac_z),
    .noise_valid (noise_valid),
    .noise_value (noise_value)
  );

endmodule

>>> hdl/gn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn_front
// Splits the coordinates of an incoming item into lattice cell and fraction.
// ----------------------------------------------------------------------------
module gn_front #(
  parameter int TABLE_SIZE    = gn_pkg::TABLE_SIZE_DEF,
  parameter int FRACTION_BITS = gn_pkg::FRACTION_BITS_DEF,
  parameter int IW            = $clog2(TABLE_SIZE),
  parameter int QW            = 1 + 4 * IW + 3 * FRACTION_BITS + gn_pkg::ENTRY_W
) (
  input  logic                                req_type,
  input  logic signed [gn_pkg::COORD_W-1:0]   coord_x,
  input  logic signed [gn_pkg::COORD_W-1:0]   coord_y,
  input  logic signed [gn_pkg::COORD_W-1:0]   coord_z,
  input  logic        [gn_pkg::ENTRY_W-1:0]   entry_index,
  input  logic        [gn_pkg::ENTRY_W-1:0]   entry_value,
  output logic        [QW-1:0]                item
);
  import gn_pkg::*;

  localparam int FB = FRACTION_BITS;

  logic [COORD_W+IW-1:0] ext_x, ext_y, ext_z;
  logic [IW-1:0]         cell_x, cell_y, cell_z, slot;

  // The floor of a signed coordinate is its arithmetic shift; the cell wraps
  // modulo the table size, so only the low bits above the fraction survive.
  assign ext_x  = {{IW{coord_x[COORD_W-1]}}, coord_x};
  assign ext_y  = {{IW{coord_y[COORD_W-1]}}, coord_y};
  assign ext_z  = {{IW{coord_z[COORD_W-1]}}, coord_z};
  assign cell_x = ext_x[FB+IW-1:FB];
  assign cell_y = ext_y[FB+IW-1:FB];
  assign cell_z = ext_z[FB+IW-1:FB];
  assign slot   = IW'(entry_index);

  assign item = {req_type, cell_x, cell_y, cell_z,
                 coord_x[FB-1:0], coord_y[FB-1:0], coord_z[FB-1:0],
                 slot, entry_value};

endmodule

>>> hdl/gn_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn_queue
// Short FIFO that decouples item intake from table sequencing.
// ----------------------------------------------------------------------------
module gn_queue #(
  parameter int WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     pop_data,
  output gn_pkg::gn_q_status_t status
);
  import gn_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [PW:0]      count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PW'(1);
      end
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  assign pop_data     = slots[rptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == (PW+1)'(QUEUE_DEPTH));

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty) else $error("queue pop while empty");

endmodule

>>> hdl/gn_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn_seq
// Owns the permutation table and walks the hash chain for each item.
// ----------------------------------------------------------------------------
module gn_seq #(
  parameter int TABLE_SIZE    = gn_pkg::TABLE_SIZE_DEF,
  parameter int FRACTION_BITS = gn_pkg::FRACTION_BITS_DEF,
  parameter int IW            = $clog2(TABLE_SIZE),
  parameter int QW            = 1 + 4 * IW + 3 * FRACTION_BITS + gn_pkg::ENTRY_W
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic [gn_pkg::MODE_W-1:0]                   mode,
  input  gn_pkg::gn_q_status_t                        q_status,
  input  logic [QW-1:0]                               q_item,
  output logic                                        q_pop,
  output logic                                        clearing,
  output gn_pkg::gn_launch_t                          launch,
  output logic [gn_pkg::HASH_N-1:0][gn_pkg::ENTRY_W-1:0] hash,
  output logic [FRACTION_BITS-1:0]                    frac_x,
  output logic [FRACTION_BITS-1:0]                    frac_y,
  output logic [FRACTION_BITS-1:0]                    frac_z
);
  import gn_pkg::*;

  localparam int FB = FRACTION_BITS;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;

  localparam logic [2:0] STEP_2D_LAST = 3'd4;
  localparam logic [2:0] STEP_3D_LAST = 3'd6;

  logic [ENTRY_W-1:0] table_mem [TABLE_SIZE];

  logic [1:0]         state;
  logic [2:0]         step;
  logic [IW-1:0]      clr_cnt;

  logic               q_req;
  logic [IW-1:0]      q_cx, q_cy, q_cz, q_slot;
  logic [FB-1:0]      q_fx, q_fy, q_fz;
  logic [ENTRY_W-1:0] q_val;

  logic [IW-1:0]      cx, cy, cz, bb;
  logic [FB-1:0]      fx, fy, fz;
  logic               two_d;
  logic [ENTRY_W-1:0] pa, pa1, pb, pb1, rd0, rd1;
  logic [3:0][ENTRY_W-1:0] hq;
  logic [5:0][ENTRY_W-1:0] early;
  logic               l_vld, l_two_d;
  logic [FB-1:0]      l_fx, l_fy, l_fz;

  logic [IW-1:0]      zoff, a0, a1, a_step1;
  logic [IW-1:0]      za_pa, za_pa1, za_pb, za_pb1;
  logic               last, we;
  logic [IW-1:0]      wa;
  logic [ENTRY_W-1:0] wd;

  assign {q_req, q_cx, q_cy, q_cz, q_fx, q_fy, q_fz, q_slot, q_val} = q_item;

  assign q_pop    = (state == S_IDLE) && !q_status.empty;
  assign clearing = (state == S_CLEAR);
  assign last     = (step == (two_d ? STEP_2D_LAST : STEP_3D_LAST));

  assign zoff    = two_d ? '0 : cz;
  assign za_pa   = IW'(pa)  + zoff;
  assign za_pa1  = IW'(pa1) + zoff;
  assign za_pb   = IW'(pb)  + zoff;
  assign za_pb1  = IW'(pb1) + zoff;
  assign a_step1 = IW'(rd0) + cy;

  // Two table reads per step: cell x, then A, then B, then the corner hashes.
  always_comb begin
    unique case (step)
      3'd0: begin a0 = cx;               a1 = cx + IW'(1);       end
      3'd1: begin a0 = a_step1;          a1 = a_step1 + IW'(1);  end
      3'd2: begin a0 = bb;               a1 = bb + IW'(1);       end
      3'd3: begin a0 = za_pa;            a1 = za_pa1;            end
      3'd4: begin a0 = za_pb;            a1 = za_pb1;            end
      3'd5: begin a0 = za_pa + IW'(1);   a1 = za_pa1 + IW'(1);   end
      3'd6: begin a0 = za_pb + IW'(1);   a1 = za_pb1 + IW'(1);   end
      default: begin a0 = cx;            a1 = cx;                end
    endcase
  end

  assign we = clearing || (q_pop && (q_req == REQ_LOAD));
  assign wa = clearing ? clr_cnt : q_slot;
  assign wd = clearing ? ENTRY_W'(clr_cnt) : q_val;

  always_ff @(posedge clk) begin
    if (we) begin
      table_mem[wa] <= wd;
    end
    rd0 <= table_mem[a0];
    rd1 <= table_mem[a1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      step    <= '0;
      clr_cnt <= '0;
      l_vld   <= 1'b0;
    end else begin
      l_vld <= (state == S_RUN) && last;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + IW'(1);
          if (clr_cnt == IW'(TABLE_SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop && (q_req == REQ_EVAL)) begin
            state <= S_RUN;
            step  <= '0;
          end
        end
        S_RUN: begin
          if (last) begin
            state <= S_IDLE;
          end else begin
            step <= step + 3'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cx    <= q_cx;
      cy    <= q_cy;
      cz    <= q_cz;
      fx    <= q_fx;
      fy    <= q_fy;
      fz    <= q_fz;
      two_d <= (mode == MODE_2D);
    end
    if (state == S_RUN) begin
      if (step == 3'd1) begin
        bb <= IW'(rd1) + cy;
      end
      if (step == 3'd2) begin
        pa  <= rd0;
        pa1 <= rd1;
      end
      if (step == 3'd3) begin
        pb  <= rd0;
        pb1 <= rd1;
      end
      if (step == 3'd4) begin
        hq[0] <= rd0;
        hq[1] <= rd1;
      end
      if (step == 3'd5) begin
        hq[2] <= rd0;
        hq[3] <= rd1;
      end
      if (last) begin
        early   <= {rd1, rd0, hq[3], hq[2], hq[1], hq[0]};
        l_two_d <= two_d;
        l_fx    <= fx;
        l_fy    <= fy;
        l_fz    <= fz;
      end
    end
  end

  // The last pair of reads lands in the read register in the same cycle as launch.
  always_comb begin
    if (l_two_d) begin
      hash = {early[3], early[2], early[1], early[0], rd1, early[5], rd0, early[4]};
    end else begin
      hash = {rd1, early[5], rd0, early[4], early[3], early[1], early[2], early[0]};
    end
  end

  assign launch.vld   = l_vld;
  assign launch.two_d = l_two_d;
  assign frac_x       = l_fx;
  assign frac_y       = l_fy;
  assign frac_z       = l_fz;

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (step <= STEP_3D_LAST)) else $error("step out of range");
  a_launch_idle: assert property (@(posedge clk) disable iff (rst)
    l_vld |-> (state == S_IDLE)) else $error("launch without return to idle");

endmodule

>>> hdl/gn_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn_lerp
// Fade curves, corner gradients and the interpolation tree, fully pipelined.
// ----------------------------------------------------------------------------
module gn_lerp #(
  parameter int FRACTION_BITS = gn_pkg::FRACTION_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  gn_pkg::gn_launch_t                             launch,
  input  logic [gn_pkg::HASH_N-1:0][gn_pkg::ENTRY_W-1:0] hash,
  input  logic [FRACTION_BITS-1:0]                       frac_x,
  input  logic [FRACTION_BITS-1:0]                       frac_y,
  input  logic [FRACTION_BITS-1:0]                       frac_z,
  output logic                                           noise_valid,
  output logic signed [gn_pkg::OUT_W-1:0]                noise_value
);
  import gn_pkg::*;

  localparam int FB    = FRACTION_BITS;
  localparam int W     = FB + 4;
  localparam int FW    = FB + 6;
  localparam int PW    = FW + W + 1;
  localparam int SH_R  = (FB > 16) ? FB - 16 : 0;
  localparam int SH_L  = (FB < 16) ? 16 - FB : 0;
  localparam int WQ    = W + SH_L;
  localparam int NST   = 8;

  localparam logic signed [W-1:0]  ONE_W   = W'(1) <<< FB;
  localparam logic signed [FW-1:0] FIFTEEN = FW'(15) <<< FB;
  localparam logic signed [FW-1:0] TEN     = FW'(10) <<< FB;
  localparam logic signed [WQ-1:0] SAT_HI  = WQ'(OUT_MAX);
  localparam logic signed [WQ-1:0] SAT_LO  = WQ'(OUT_MIN);

  localparam logic [3:0] H_SWAP_A = 4'd12;
  localparam logic [3:0] H_SWAP_B = 4'd14;

  function automatic logic signed [W-1:0] grad3(input logic [3:0] h,
      input logic signed [W-1:0] x, input logic signed [W-1:0] y,
      input logic signed [W-1:0] z);
    logic signed [W-1:0] u, v;
    u = h[3] ? y : x;
    v = (h[3:2] == 2'd0) ? y : ((h == H_SWAP_A || h == H_SWAP_B) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic signed [W-1:0] grad2(input logic [1:0] h,
      input logic signed [W-1:0] x, input logic signed [W-1:0] y);
    logic signed [W-1:0] u, v;
    u = h[1] ? y : x;
    v = h[1] ? x : y;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  logic [NST-1:0] vld_sr, td_sr;

  logic [FB-1:0]          t_in [3];
  logic signed [W-1:0]    off0 [3];
  logic signed [W-1:0]    off1 [3];
  logic signed [W-1:0]    g    [HASH_N];
  logic signed [FW-1:0]   tw   [3];
  logic signed [FW-1:0]   fa   [3];

  logic signed [W-1:0]    s1_g [HASH_N];
  logic signed [2*FW-1:0] s1_ta [3];
  logic [2*FB-1:0]        s1_tt [3];
  logic [FB-1:0]          s1_t  [3];

  logic signed [W-1:0]    s2_g [HASH_N];
  logic signed [FW-1:0]   s2_b   [3];
  logic [2*FB-1:0]        s2_t3p [3];

  logic signed [W-1:0]    s3_g [HASH_N];
  logic signed [2*FW-1:0] s3_fp [3];

  logic signed [FW-1:0]   fd [3];
  logic signed [W-1:0]    s4_base [4];
  logic signed [PW-1:0]   s4_prod [4];
  logic signed [FW-1:0]   s4_fv, s4_fw;

  logic signed [W-1:0]    s5_xl [4];
  logic signed [FW-1:0]   s5_fv, s5_fw;

  logic signed [W-1:0]    s6_base [2];
  logic signed [PW-1:0]   s6_prod [2];
  logic signed [FW-1:0]   s6_fw;

  logic signed [W-1:0]    s7_yl [2];
  logic signed [FW-1:0]   s7_fw;

  logic signed [W-1:0]    s8_base;
  logic signed [PW-1:0]   s8_prod;

  logic signed [W-1:0]    res;
  logic signed [WQ-1:0]   rq;

  assign t_in[0] = frac_x;
  assign t_in[1] = frac_y;
  assign t_in[2] = frac_z;

  // Corner offsets and gradients; corner bit 0 is x, bit 1 is y, bit 2 is z.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off0[i] = $signed({{(W-FB){1'b0}}, t_in[i]});
      off1[i] = off0[i] - ONE_W;
      tw[i]   = $signed({{(FW-FB){1'b0}}, t_in[i]});
      fa[i]   = (tw[i] <<< 2) + (tw[i] <<< 1) - FIFTEEN;
    end
    for (int c = 0; c < HASH_N; c++) begin
      if (launch.two_d) begin
        g[c] = grad2(hash[c][1:0], c[0] ? off1[0] : off0[0], c[1] ? off1[1] : off0[1]);
      end else begin
        g[c] = grad3(hash[c][3:0], c[0] ? off1[0] : off0[0],
                     c[1] ? off1[1] : off0[1], c[2] ? off1[2] : off0[2]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      fd[i] = FW'(s3_fp[i] >>> FB);
    end
    res = td_sr[NST-1] ? s8_base : s8_base + W'(s8_prod >>> FB);
    rq  = (WQ'(res) <<< SH_L) >>> SH_R;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sr      <= '0;
      noise_valid <= 1'b0;
    end else begin
      vld_sr      <= {vld_sr[NST-2:0], launch.vld};
      noise_valid <= vld_sr[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    td_sr <= {td_sr[NST-2:0], launch.two_d};
    // Fade: a = 6t - 15, b = t*a + 10, t3 = t*t*t, fade = t3*b.
    for (int i = 0; i < 3; i++) begin
      s1_ta[i]  <= tw[i] * fa[i];
      s1_tt[i]  <= t_in[i] * t_in[i];
      s1_t[i]   <= t_in[i];
      s2_b[i]   <= FW'(s1_ta[i] >>> FB) + TEN;
      s2_t3p[i] <= s1_tt[i][2*FB-1:FB] * s1_t[i];
      s3_fp[i]  <= $signed({{(FW-FB){1'b0}}, s2_t3p[i][2*FB-1:FB]}) * s2_b[i];
    end
    for (int c = 0; c < HASH_N; c++) begin
      s1_g[c] <= g[c];
      s2_g[c] <= s1_g[c];
      s3_g[c] <= s2_g[c];
    end
    // Lerps along x, then y, then z.
    for (int k = 0; k < 4; k++) begin
      s4_base[k] <= s3_g[2*k];
      s4_prod[k] <= fd[0] * ((W+1)'(s3_g[2*k+1]) - (W+1)'(s3_g[2*k]));
      s5_xl[k]   <= s4_base[k] + W'(s4_prod[k] >>> FB);
    end
    s4_fv <= fd[1];
    s4_fw <= fd[2];
    s5_fv <= s4_fv;
    s5_fw <= s4_fw;
    for (int k = 0; k < 2; k++) begin
      s6_base[k] <= s5_xl[2*k];
      s6_prod[k] <= s5_fv * ((W+1)'(s5_xl[2*k+1]) - (W+1)'(s5_xl[2*k]));
      s7_yl[k]   <= s6_base[k] + W'(s6_prod[k] >>> FB);
    end
    s6_fw   <= s5_fw;
    s7_fw   <= s6_fw;
    s8_base <= s7_yl[0];
    s8_prod <= s7_fw * ((W+1)'(s7_yl[1]) - (W+1)'(s7_yl[0]));
    if (rq > SAT_HI) begin
      noise_value <= OUT_W'(SAT_HI);
    end else if (rq < SAT_LO) begin
      noise_value <= OUT_W'(SAT_LO);
    end else begin
      noise_value <= OUT_W'(rq);
    end
  end

endmodule
